[rtl/base64_stream_codec_macros.svh]
// ----------------------------------------------------------------------------
// base64_stream_codec_macros: assertion helpers
// Concurrent assertion macros for the codec; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define B64SC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("b64sc assertion failed");

// condition must never be true out of reset
`define B64SC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("b64sc forbidden condition");

`else

`define B64SC_ASSERT(lbl, clk, rst_n, prop)
`define B64SC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/b64sc_pkg.sv]
// ----------------------------------------------------------------------------
// b64sc_pkg: shared types and alphabet functions
// Job word passed from front to back, queue status and the symbol maps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64sc_pkg;

  localparam logic [7:0] PadChar   = 8'd61;  // '='
  localparam logic [7:0] SpaceChar = 8'd32;  // ' '
  localparam logic [7:0] PlusChar  = 8'd43;  // '+'
  localparam logic [7:0] SlashChar = 8'd47;  // '/'

  // one completed group, aligned to the top of the 24-bit word
  typedef struct packed {
    logic        mode;   // 1: decode job
    logic [23:0] bits;
    logic [1:0]  k;      // encode: index of last real symbol
    logic        last;
    logic        bad;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_val_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] sym_of(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return w + 8'd65;
    else if (v < 6'd52) return w + 8'd71;
    else if (v < 6'd62) return w - 8'd4;
    else if (v == 6'd62) return PlusChar;
    else                return SlashChar;
  endfunction

  // alphabet character to 6-bit value, pad counts as zero
  function automatic sym_val_t val_of(input logic [7:0] c);
    sym_val_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'd65 && c <= 8'd90)       r.val = 6'(c - 8'd65);
    else if (c >= 8'd97 && c <= 8'd122) r.val = 6'(c - 8'd71);
    else if (c >= 8'd48 && c <= 8'd57)  r.val = 6'(c + 8'd4);
    else if (c == PlusChar)             r.val = 6'd62;
    else if (c == SlashChar)            r.val = 6'd63;
    else if (c == PadChar)              r.val = 6'd0;
    else                                r.ok  = 1'b0;
    return r;
  endfunction

endpackage

[rtl/b64sc_front.sv]
// ----------------------------------------------------------------------------
// b64sc_front: group builder
// Holds the mode register, gathers words into groups and issues a job per
// completed or flushed group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64sc_front import b64sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       decode_mode_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       in_last_i,
  output logic       job_push_o,
  output job_t       job_o
);

  logic        mode_q;
  logic [23:0] bits_q;
  logic [1:0]  fill_q;
  logic        bad_q;

  logic [1:0]  fill_n;
  logic [23:0] enc_bits, dec_bits, enc_full, dec_full;
  sym_val_t    sv;
  logic        bad_n;
  logic        emit;

  // next group contents for both modes
  always_comb begin
    fill_n   = fill_q + 2'd1;
    enc_bits = {bits_q[15:0], data_byte_i};
    sv       = val_of(data_byte_i);
    dec_bits = {bits_q[17:0], sv.val};
    bad_n    = bad_q | ~sv.ok;
    unique case (fill_n)
      2'd1:    enc_full = {enc_bits[7:0], 16'd0};
      2'd2:    enc_full = {enc_bits[15:0], 8'd0};
      default: enc_full = enc_bits;
    endcase
    unique case (fill_n)
      2'd1: dec_full = {dec_bits[5:0], 18'd0};
      2'd2: dec_full = {dec_bits[11:0], 12'd0};
      2'd3: dec_full = {dec_bits[17:0], 6'd0};
      2'd0: dec_full = dec_bits;
    endcase
  end

  // group closes on a full group or a flush
  always_comb begin
    if (mode_q) begin
      emit = (fill_n == 2'd0) || in_last_i;
    end else begin
      emit = (fill_n == 2'd3) || in_last_i;
    end
    job_o.mode = mode_q;
    job_o.bits = mode_q ? dec_full : enc_full;
    job_o.k    = fill_n;
    job_o.last = in_last_i;
    job_o.bad  = mode_q & bad_n;
    job_push_o = accept_i & emit;
  end

  // mode register and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      bits_q <= '0;
      fill_q <= '0;
      bad_q  <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= decode_mode_i;
      bits_q <= '0;
      fill_q <= '0;
      bad_q  <= 1'b0;
    end else if (accept_i) begin
      if (emit) begin
        bits_q <= '0;
        fill_q <= '0;
        bad_q  <= 1'b0;
      end else begin
        bits_q <= mode_q ? dec_bits : enc_bits;
        fill_q <= fill_n;
        bad_q  <= mode_q & bad_n;
      end
    end
  end

endmodule

[rtl/b64sc_job_fifo.sv]
// ----------------------------------------------------------------------------
// b64sc_job_fifo: two-entry job queue
// Decouples the group builder from the result serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64sc_job_fifo import b64sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output job_t       job_o,
  output fifo_stat_t stat_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign job_o        = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

[rtl/b64sc_back.sv]
// ----------------------------------------------------------------------------
// b64sc_back: result serializer
// Expands each job into three or four words and writes them into the output
// register, one per cycle while that register is popped or empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64sc_back import b64sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  fifo_stat_t stat_i,
  output logic       job_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       bad_symbol_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, bad_q;

  logic       load;
  logic       end_idx;
  logic [5:0] six;
  logic [7:0] dbyte, res_byte;

  // select the result word for the current index
  always_comb begin
    unique case (idx_q)
      2'd0: six = job_i.bits[23:18];
      2'd1: six = job_i.bits[17:12];
      2'd2: six = job_i.bits[11:6];
      2'd3: six = job_i.bits[5:0];
    endcase
    unique case (idx_q)
      2'd0:    dbyte = job_i.bits[23:16];
      2'd1:    dbyte = job_i.bits[15:8];
      default: dbyte = job_i.bits[7:0];
    endcase
    if (job_i.mode) begin
      res_byte = (dbyte == 8'd0) ? SpaceChar : dbyte;
      end_idx  = (idx_q == 2'd2);
    end else begin
      res_byte = (idx_q <= job_i.k) ? sym_of(six) : PadChar;
      end_idx  = (idx_q == 2'd3);
    end
    load      = !stat_i.empty && (!valid_q || pop_i);
    job_pop_o = load && end_idx;
  end

  // word index within the job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= end_idx ? 2'd0 : idx_q + 2'd1;
      if (load)       valid_q <= 1'b1;
      else if (pop_i) valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= res_byte;
      last_q <= job_i.last & end_idx;
      bad_q  <= job_i.bad;
    end
  end

  assign empty_o      = ~valid_q;
  assign out_byte_o   = byte_q;
  assign out_last_o   = last_q;
  assign bad_symbol_o = bad_q;

endmodule

[rtl/base64_stream_codec.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming Base64 encoder / decoder
// Input words enter with push/full, results leave with empty/pop.
// ----------------------------------------------------------------------------
// Usage:
//   decode_mode is written on the cfg channel (cfg_valid_i, always ready)
//   while the block is idle; a write drops any partial group.
//   Encode: every third byte, or a byte with in_last_i, yields four symbols
//   ('=' for missing bytes). Decode: every fourth symbol, or one with
//   in_last_i, yields three bytes, zero bytes shown as space; bad_symbol_o
//   flags every byte of a group that held a non-alphabet symbol.
//   The word that closes a group is pushed into the job queue as it is
//   accepted; the serializer then moves the group's results from the queue
//   head into the output register, one result per cycle while pop keeps up.
//   Input is taken every cycle while the two-entry job queue has room.
//   Sustained, decode takes one symbol per cycle; encode is held back by
//   the serializer, which writes four symbols for every three bytes.
//   Reset clears the mode (encode), the group and all queues.
//   When pop is held low the output register holds, the job queue fills
//   and full is raised; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "base64_stream_codec_macros.svh"

module base64_stream_codec import b64sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       decode_mode_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       bad_symbol_o
);

  logic       accept;
  logic       job_push, job_pop;
  job_t       job_in, job_head;
  fifo_stat_t fstat;

  assign cfg_ready_o = 1'b1;
  assign full        = fstat.full;
  assign accept      = push & ~fstat.full;

  // group builder
  b64sc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .decode_mode_i (decode_mode_i),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .in_last_i     (in_last_i),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  // job queue
  b64sc_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .job_o  (job_head),
    .stat_o (fstat)
  );

  // result serializer
  b64sc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_head),
    .stat_i       (fstat),
    .job_pop_o    (job_pop),
    .pop_i        (pop & ~empty),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .bad_symbol_o (bad_symbol_o)
  );

  // queue status and job sanity
  `B64SC_ASSERT_NEVER(a_fifo_full_empty, clk_i, rst_ni, fstat.full && fstat.empty)
  `B64SC_ASSERT(a_pop_nonempty, clk_i, rst_ni, job_pop |-> !fstat.empty)
  `B64SC_ASSERT(a_enc_no_bad, clk_i, rst_ni, (job_push && !job_in.mode) |-> !job_in.bad)
  `B64SC_ASSERT(a_push_room, clk_i, rst_ni, (fstat.full && !job_pop) |=> !$rose(fstat.empty))

endmodule

[sim/base64_codec_checker.sv]
// ----------------------------------------------------------------------------
// base64_codec_checker: scoreboard for the streaming Base64 codec
// Watches the mode, input and result channels, predicts every result word
// from the accepted input words and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_codec_checker import b64sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       decode_mode_i,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] data_byte_i,
  input  logic       in_last_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  input  logic       bad_symbol_i,
  output int         mismatches_o,
  output int         open_chars_o
);

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       bad;
  } char_word_t;

  typedef struct packed {
    logic       known;
    logic [5:0] idx;
  } sym_t;

  // mirrored codec state
  logic        mode_q;
  logic [23:0] grp_q;
  logic [1:0]  fill_q;
  logic        bad_q;

  char_word_t awaited_chars[$];
  int         mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  // 6-bit index to alphabet character
  function automatic logic [7:0] index_to_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx == 6'd63) return SlashChar;
    if (idx == 6'd62) return PlusChar;
    if (idx >= 6'd52) return "0" + (wide - 8'd52);
    if (idx >= 6'd26) return "a" + (wide - 8'd26);
    return "A" + wide;
  endfunction

  // alphabet character to 6-bit index, pad is a known zero
  function automatic sym_t char_to_index(input logic [7:0] c);
    sym_t s;
    s.known = 1'b1;
    s.idx   = 6'd0;
    if (c >= "A" && c <= "Z")      s.idx = 6'(c - "A");
    else if (c >= "a" && c <= "z") s.idx = 6'(c - "a" + 8'd26);
    else if (c >= "0" && c <= "9") s.idx = 6'(c - "0" + 8'd52);
    else if (c == PlusChar)        s.idx = 6'd62;
    else if (c == SlashChar)       s.idx = 6'd63;
    else if (c != PadChar)         s.known = 1'b0;
    return s;
  endfunction

  task automatic clear_group();
    grp_q  = '0;
    fill_q = '0;
    bad_q  = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_total++;
    if (mismatch_total <= 40)
      $display("[%0t] codec check: %s got %h want %h", $time, what, got, want);
  endtask

  // fold one input word into the group and queue the words it releases
  task automatic translate_word(input logic [7:0] b, input logic last);
    logic [23:0] grp;
    logic [23:0] aligned;
    logic [2:0]  took;
    logic        bad;
    sym_t        sym;
    char_word_t  w;
    took = {1'b0, fill_q} + 3'd1;
    if (!mode_q) begin
      // encode: three bytes or a final byte give four symbols
      grp = {grp_q[15:0], b};
      if (took == 3'd3 || last) begin
        aligned = grp << (8 * (3 - took));
        for (int i = 0; i < 4; i++) begin
          w.chr  = (i <= took) ? index_to_char(aligned[23 - 6 * i -: 6]) : PadChar;
          w.last = last && (i == 3);
          w.bad  = 1'b0;
          awaited_chars.push_back(w);
        end
        clear_group();
      end else begin
        grp_q  = grp;
        fill_q = took[1:0];
      end
    end else begin
      // decode: four symbols or a final symbol give three bytes
      sym = char_to_index(b);
      grp = {grp_q[17:0], sym.idx};
      bad = bad_q | ~sym.known;
      if (took == 3'd4 || last) begin
        aligned = grp << (6 * (4 - took));
        for (int i = 0; i < 3; i++) begin
          w.chr  = aligned[23 - 8 * i -: 8];
          if (w.chr == 8'd0) w.chr = SpaceChar;
          w.last = last && (i == 2);
          w.bad  = bad;
          awaited_chars.push_back(w);
        end
        clear_group();
      end else begin
        grp_q  = grp;
        fill_q = took[1:0];
        bad_q  = bad;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    char_word_t w;
    if (!rst_ni) begin
      mode_q = 1'b0;
      clear_group();
      awaited_chars.delete();
      open_chars_o <= 0;
    end else begin
      // result side first: a result never stems from a same-edge input
      if (pop_i && !empty_i) begin
        if (awaited_chars.size() == 0) begin
          report_mismatch("result word with none awaited, out_byte", out_byte_i, 8'h00);
        end else begin
          w = awaited_chars.pop_front();
          if (out_byte_i !== w.chr)
            report_mismatch("out_byte", out_byte_i, w.chr);
          if (out_last_i !== w.last)
            report_mismatch("out_last", {7'b0, out_last_i}, {7'b0, w.last});
          if (bad_symbol_i !== w.bad)
            report_mismatch("bad_symbol", {7'b0, bad_symbol_i}, {7'b0, w.bad});
        end
      end
      // mode write drops the partial group
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q = decode_mode_i;
        clear_group();
      end
      if (push_i && !full_i) translate_word(data_byte_i, in_last_i);
      open_chars_o <= awaited_chars.size();
    end
  end

endmodule

[sim/tb_base64_stream_codec.sv]
// ----------------------------------------------------------------------------
// tb_base64_stream_codec: testbench top for the streaming Base64 codec
// Directed encode and decode words, then random messages in both modes
// under several sender idle and receiver stall mixes, one long output
// hold-off; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_base64_stream_codec import b64sc_pkg::*;;

  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 10;
  localparam int PhaseWords   = 15;
  localparam int TimeoutNs    = 400_000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       decode_mode;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       in_last;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_symbol;

  int   mismatches;
  int   open_chars;
  int   words_sent = 0;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;

  base64_stream_codec i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .decode_mode_i(decode_mode),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte),
    .in_last_i    (in_last),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte),
    .out_last_o   (out_last),
    .bad_symbol_o (bad_symbol)
  );

  base64_codec_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .decode_mode_i(decode_mode),
    .push_i       (push),
    .full_i       (full),
    .data_byte_i  (data_byte),
    .in_last_i    (in_last),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_byte_i   (out_byte),
    .out_last_i   (out_last),
    .bad_symbol_i (bad_symbol),
    .mismatches_o (mismatches),
    .open_chars_o (open_chars)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk_i) begin
    pop <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // long output hold-off, counted here once requested
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #TimeoutNs;
    $display("tb: failure");
    $finish;
  end

  // offer one word, return at the edge that accepts it
  task automatic offer_word(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= b;
    in_last   <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
  endtask

  // stop sending until every predicted word has come out
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (open_chars != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid   <= 1'b1;
    decode_mode <= m;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 4))
      0:       return "A" + 8'($urandom_range(0, 25));
      1:       return "a" + 8'($urandom_range(0, 25));
      2:       return "0" + 8'($urandom_range(0, 9));
      3:       return PlusChar;
      default: return SlashChar;
    endcase
  endfunction

  // raw bytes, mostly closed by a final marker
  task automatic send_byte_message();
    int len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++)
      offer_word(8'($urandom_range(0, 255)),
                 (i == len - 1) && ($urandom_range(0, 4) != 0));
  endtask

  // mostly well-formed text with optional padding, some noise
  task automatic send_symbol_message();
    logic [7:0] syms[$];
    int groups;
    int tail;
    if ($urandom_range(0, 99) < 80) begin
      groups = $urandom_range(0, 3);
      tail   = $urandom_range(0, 3);
      if (groups == 0 && tail == 0) tail = 2;
      repeat (4 * groups + tail) syms.push_back(pick_symbol());
      if (tail >= 2 && $urandom_range(0, 1) == 1)
        repeat (4 - tail) syms.push_back(PadChar);
      for (int i = 0; i < syms.size(); i++)
        offer_word(syms[i], i == syms.size() - 1);
    end else begin
      tail = $urandom_range(1, 8);
      for (int i = 0; i < tail; i++)
        offer_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic run_phase(input logic m, input int idle, input int stall, input int count);
    int start;
    write_mode(m);
    tx_idle_pct = idle;
    rx_stall_pct <= stall;
    start = words_sent;
    while (words_sent - start < count) begin
      if (m) send_symbol_message();
      else   send_byte_message();
    end
    wait_drained();
  endtask

  initial begin
    int start;
    rst_ni      <= 1'b0;
    cfg_valid   <= 1'b0;
    decode_mode <= 1'b0;
    push        <= 1'b0;
    data_byte   <= 8'h00;
    in_last     <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // encode: one byte, two bytes, '+' and '/' group, full group with final marker
    write_mode(1'b0);
    offer_word(8'h00, 1'b1);
    offer_word(8'hFF, 1'b0);
    offer_word(8'h00, 1'b1);
    offer_word(8'hFB, 1'b0);
    offer_word(8'hFF, 1'b0);
    offer_word(8'hBF, 1'b0);
    offer_word(8'h80, 1'b0);
    offer_word(8'h7F, 1'b0);
    offer_word(8'h01, 1'b1);
    wait_drained();

    // decode: plain group, short final group, all pads as spaces,
    // unknown symbols in a full final group, single final symbol
    write_mode(1'b1);
    offer_word("T", 1'b0);
    offer_word("W", 1'b0);
    offer_word("F", 1'b0);
    offer_word("u", 1'b0);
    offer_word(SlashChar, 1'b0);
    offer_word(PlusChar, 1'b1);
    repeat (4) offer_word(PadChar, 1'b0);
    offer_word("z", 1'b0);
    offer_word(8'hFF, 1'b0);
    offer_word("9", 1'b0);
    offer_word("!", 1'b1);
    offer_word("A", 1'b1);
    wait_drained();

    // random phases: both modes under each idle and stall mix
    for (int p = 0; p < 8; p++) begin
      case (p >> 1)
        0:       run_phase(p[0], 0, 0, PhaseWords);
        1:       run_phase(p[0], 51, 0, PhaseWords);
        2:       run_phase(p[0], 0, 51, PhaseWords);
        default: run_phase(p[0], 21, 21, PhaseWords);
      endcase
    end

    // back-pressure: output held off while input keeps coming
    write_mode(1'b0);
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    hold_go <= 1'b1;
    start = words_sent;
    while (words_sent - start < 34) send_byte_message();
    wait_drained();

    if (mismatches == 0 && open_chars == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
